### rtl/sinosc_pkg.sv
// ----------------------------------------------------------------------------
// sinosc_pkg
// Shared widths, defaults, command and divider types, and back-end states
// for the sine oscillator with glide.
// ----------------------------------------------------------------------------
package sinosc_pkg;

  // field widths
  localparam int LEN_W    = 13;  // block length
  localparam int STEP_W   = 32;  // target phase step
  localparam int LEVEL_W  = 15;  // target level, Q0.15
  localparam int SAMPLE_W = 16;  // output sample
  localparam int FRAC_W   = 16;  // fraction bits of step and gain accumulators
  localparam int ACC_W    = STEP_W + FRAC_W;  // Q32.16 step
  localparam int GAIN_W   = 32;               // Q15.16 gain
  localparam int MAG_W    = 15;               // sine table magnitude

  // parameter defaults
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int MAX_BLOCK_DEF        = 4096;
  localparam int PHASE_BITS_DEF       = 32;

  // command queue depth, power of two
  localparam int QUEUE_DEPTH = 4;

  // pi/2 in Q30, used to build the quarter-wave table
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SINE_MAX    = 64'd32767;

  // one classified request
  typedef struct packed {
    logic               start;
    logic [LEN_W-1:0]   len;
    logic [STEP_W-1:0]  step;
    logic [LEVEL_W-1:0] level;
  } cmd_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [LEN_W-1:0]  denom;
    logic [ACC_W-1:0]  num_step;
    logic [GAIN_W-1:0] num_gain;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ACC_W-1:0]  quo_step;
    logic [GAIN_W-1:0] quo_gain;
  } div_rsp_t;

  typedef enum logic [0:0] {
    ST_RUN,
    ST_DIV
  } back_state_t;

endpackage

### rtl/sinosc_if.sv
// ----------------------------------------------------------------------------
// sinosc_if
// Valid/ready channels of the oscillator: control ticks in, samples out.
// ----------------------------------------------------------------------------
interface sinosc_in_if;
  logic                             valid;
  logic                             ready;
  logic                             block_start;
  logic [sinosc_pkg::LEN_W-1:0]     block_length;
  logic [sinosc_pkg::STEP_W-1:0]    target_step;
  logic [sinosc_pkg::LEVEL_W-1:0]   target_level;

  modport source (output valid, block_start, block_length, target_step, target_level,
                  input ready);
  modport sink (input valid, block_start, block_length, target_step, target_level,
                output ready);
endinterface

interface sinosc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sinosc_pkg::SAMPLE_W-1:0] sample;
  logic                                block_end;

  modport source (output valid, sample, block_end, input ready);
  modport sink (input valid, sample, block_end, output ready);
endinterface

### rtl/sinosc_front.sv
// ----------------------------------------------------------------------------
// sinosc_front
// Takes control ticks, clamps the block length and hands each request
// to the command queue.
// ----------------------------------------------------------------------------
module sinosc_front #(
  parameter int MAX_BLOCK = sinosc_pkg::MAX_BLOCK_DEF
) (
  sinosc_in_if.sink          ctrl,
  output sinosc_pkg::cmd_t   cmd,
  output logic               push,
  input  logic               room
);
  import sinosc_pkg::*;

  localparam int LenTop = (1 << LEN_W) - 1;
  localparam int LenCap = (MAX_BLOCK < LenTop) ? MAX_BLOCK : LenTop;

  logic [LEN_W-1:0] len_fixed;

  // zero length counts as one, long blocks clamp to the maximum
  always_comb begin
    priority if (ctrl.block_length == '0) begin
      len_fixed = LEN_W'(1);
    end else if (ctrl.block_length > LEN_W'(LenCap)) begin
      len_fixed = LEN_W'(LenCap);
    end else begin
      len_fixed = ctrl.block_length;
    end
  end

  // classified request
  always_comb begin
    cmd.start = ctrl.block_start;
    cmd.len   = len_fixed;
    cmd.step  = ctrl.target_step;
    cmd.level = ctrl.target_level;
  end

  assign ctrl.ready = room;
  assign push       = ctrl.valid & room;

endmodule

### rtl/sinosc_queue.sv
// ----------------------------------------------------------------------------
// sinosc_queue
// Small FIFO of classified requests between the front and the back end.
// ----------------------------------------------------------------------------
module sinosc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sinosc_pkg::cmd_t wr_cmd,
  output logic             room,
  input  logic             pop,
  output logic             head_valid,
  output sinosc_pkg::cmd_t head_cmd
);
  import sinosc_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = PtrW + 1;

  cmd_t            entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign room       = (fill != CntW'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + CntW'(1);
        2'b01:   fill <= fill - CntW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

### rtl/sinosc_div.sv
// ----------------------------------------------------------------------------
// sinosc_div
// Restoring divider, one quotient bit per cycle, for the step and gain
// slopes. Both numerators share the block length as divisor.
// ----------------------------------------------------------------------------
module sinosc_div (
  input  logic                 clk,
  input  logic                 rst,
  input  sinosc_pkg::div_req_t req,
  output sinosc_pkg::div_rsp_t rsp
);
  import sinosc_pkg::*;

  localparam int CntW      = $clog2(ACC_W);
  localparam int GainStart = ACC_W - GAIN_W;

  logic              busy;
  logic              done;
  logic [CntW-1:0]   count;
  logic [ACC_W-1:0]  qs;
  logic [GAIN_W-1:0] qg;
  logic [LEN_W-1:0]  rs;
  logic [LEN_W-1:0]  rg;
  logic [LEN_W-1:0]  d;

  logic [LEN_W:0]    trial_s;
  logic [LEN_W:0]    trial_g;
  logic              fit_s;
  logic              fit_g;
  logic [LEN_W-1:0]  rs_next;
  logic [LEN_W-1:0]  rg_next;
  logic              gain_on;

  // one trial subtraction per lane
  always_comb begin
    trial_s = {rs, qs[ACC_W-1]};
    trial_g = {rg, qg[GAIN_W-1]};
    fit_s   = (trial_s >= {1'b0, d});
    fit_g   = (trial_g >= {1'b0, d});
    rs_next = fit_s ? LEN_W'(trial_s - {1'b0, d}) : trial_s[LEN_W-1:0];
    rg_next = fit_g ? LEN_W'(trial_g - {1'b0, d}) : trial_g[LEN_W-1:0];
    // the narrower gain lane runs over the last steps only
    gain_on = (count >= CntW'(GainStart));
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CntW'(1);
        if (count == CntW'(ACC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder shift registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      qs <= req.num_step;
      qg <= req.num_gain;
      rs <= '0;
      rg <= '0;
      d  <= req.denom;
    end else if (busy) begin
      qs <= {qs[ACC_W-2:0], fit_s};
      rs <= rs_next;
      if (gain_on) begin
        qg <= {qg[GAIN_W-2:0], fit_g};
        rg <= rg_next;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quo_step = qs;
  assign rsp.quo_gain = qg;

endmodule

### rtl/sinosc_back.sv
// ----------------------------------------------------------------------------
// sinosc_back
// Oscillator core: latches block targets through the divider, steps the
// phase, glide and gain ramp, and runs the table and gain pipeline.
// ----------------------------------------------------------------------------
module sinosc_back #(
  parameter int SINE_TABLE_DEPTH = sinosc_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS       = sinosc_pkg::PHASE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  sinosc_pkg::cmd_t     head_cmd,
  output logic                 pop,
  output sinosc_pkg::div_req_t div_req,
  input  sinosc_pkg::div_rsp_t div_rsp,
  sinosc_out_if.source         audio
);
  import sinosc_pkg::*;

  localparam int Quarter = SINE_TABLE_DEPTH / 4;
  localparam int QB      = $clog2(Quarter);
  localparam int IB      = QB + 2;
  localparam int AW      = QB + 1;
  localparam int PROD_W  = MAG_W + FRAC_W;

  // quarter-wave table, Taylor series in Q30 worked out at elaboration
  logic [MAG_W-1:0] sine_rom [Quarter+1];

  for (genvar i = 0; i <= Quarter; i++) begin : g_rom
    localparam logic [63:0] X  = (64'(i) * HALF_PI_Q30) / 64'(Quarter);
    localparam logic [63:0] X2 = (X * X) >> 30;
    localparam logic [63:0] T1 = ((X * X2) >> 30) / 64'd6;
    localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
    localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
    localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
    localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
    localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
    localparam logic [63:0] S  = X - T1 + T2 - T3 + T4 - T5 + T6;
    localparam logic [63:0] R  = (S + 64'd16384) >> 15;
    localparam logic [63:0] E  = (R > SINE_MAX) ? SINE_MAX : R;
    assign sine_rom[i] = E[MAG_W-1:0];
  end

  back_state_t state;
  back_state_t state_next;

  // oscillator state
  logic [PHASE_BITS-1:0] phase;
  logic [ACC_W-1:0]      cs;      // current step
  logic [ACC_W-1:0]      ahead;   // current step plus slope
  logic [ACC_W-1:0]      sd;      // step slope
  logic [GAIN_W-1:0]     cg;      // current gain
  logic [GAIN_W-1:0]     gd;      // gain slope
  logic [LEN_W-1:0]      sl;      // samples left
  logic [STEP_W-1:0]     end_step;
  logic [LEVEL_W-1:0]    end_level;
  logic                  latched;
  logic                  step_neg;
  logic                  gain_neg;

  logic                  en;
  logic                  issue;
  logic                  load;
  logic                  div_start;

  // target differences, magnitude and sign
  logic [ACC_W-1:0]      t_step;
  logic [GAIN_W-1:0]     t_gain;
  logic                  step_below;
  logic                  gain_below;

  // table addressing
  logic [IB-1:0]         idx;
  logic [1:0]            quad;
  logic [QB-1:0]         w;
  logic [AW-1:0]         addr;

  // sample pipeline
  logic                  v0, v1, v2, v3;
  logic [AW-1:0]         addr0;
  logic                  neg0, neg1, neg2;
  logic                  end0, end1, end2, end3;
  logic [FRAC_W-1:0]     gain0, gain1;
  logic [MAG_W-1:0]      mag1;
  logic [PROD_W-1:0]     prod2;
  logic [PROD_W-1:0]     rounded;
  logic [SAMPLE_W-1:0]   mag_r;
  logic signed [SAMPLE_W-1:0] sample3;

  assign en = !v3 || audio.ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    issue      = 1'b0;
    load       = 1'b0;
    unique case (state)
      ST_RUN: begin
        if (head_valid && head_cmd.start && !latched) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else if (head_valid && en) begin
          issue = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          load       = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  assign pop = issue;

  // divider operands: |target - current| over the block length
  always_comb begin
    t_step     = {head_cmd.step, {FRAC_W{1'b0}}};
    t_gain     = {1'b0, head_cmd.level, {FRAC_W{1'b0}}};
    step_below = (t_step < cs);
    gain_below = (t_gain < cg);
    div_req.start    = div_start;
    div_req.denom    = head_cmd.len;
    div_req.num_step = step_below ? (cs - t_step) : (t_step - cs);
    div_req.num_gain = gain_below ? (cg - t_gain) : (t_gain - cg);
  end

  // table address from the phase
  always_comb begin
    idx  = phase[PHASE_BITS-1 -: IB];
    quad = idx[IB-1 -: 2];
    w    = idx[QB-1:0];
    addr = quad[0] ? (AW'(Quarter) - {1'b0, w}) : {1'b0, w};
  end

  // oscillator state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      cs        <= '0;
      ahead     <= '0;
      sd        <= '0;
      cg        <= '0;
      gd        <= '0;
      sl        <= '0;
      end_step  <= '0;
      end_level <= '0;
      latched   <= 1'b0;
      step_neg  <= 1'b0;
      gain_neg  <= 1'b0;
    end else begin
      if (div_start) begin
        step_neg <= step_below;
        gain_neg <= gain_below;
      end
      if (load) begin
        sd        <= step_neg ? (ACC_W'(0) - div_rsp.quo_step) : div_rsp.quo_step;
        ahead     <= step_neg ? (cs - div_rsp.quo_step) : (cs + div_rsp.quo_step);
        gd        <= gain_neg ? (GAIN_W'(0) - div_rsp.quo_gain) : div_rsp.quo_gain;
        sl        <= head_cmd.len;
        end_step  <= head_cmd.step;
        end_level <= head_cmd.level;
        latched   <= 1'b1;
      end
      if (issue) begin
        latched <= 1'b0;
        phase   <= phase + ahead[ACC_W-1 -: PHASE_BITS];
        if (sl == LEN_W'(1)) begin
          // last sample of the block: snap to the targets
          sl    <= '0;
          cs    <= {end_step, {FRAC_W{1'b0}}};
          ahead <= {end_step, {FRAC_W{1'b0}}};
          cg    <= {1'b0, end_level, {FRAC_W{1'b0}}};
          sd    <= '0;
          gd    <= '0;
        end else begin
          // slopes are zero outside a block, so this also holds steady
          cs    <= ahead;
          ahead <= ahead + sd;
          cg    <= cg + gd;
          if (sl != '0) begin
            sl <= sl - LEN_W'(1);
          end
        end
      end
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= issue;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // table read, gain multiply, rounding
  always_comb begin
    rounded = prod2 + PROD_W'(1 << 14);
    mag_r   = rounded[PROD_W-1 -: SAMPLE_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      addr0   <= addr;
      neg0    <= quad[1];
      gain0   <= cg[GAIN_W-1 -: FRAC_W];
      end0    <= (sl == LEN_W'(1));
      mag1    <= sine_rom[addr0];
      neg1    <= neg0;
      gain1   <= gain0;
      end1    <= end0;
      prod2   <= PROD_W'(mag1) * PROD_W'(gain1);
      neg2    <= neg1;
      end2    <= end1;
      sample3 <= neg2 ? -$signed(mag_r) : $signed(mag_r);
      end3    <= end2;
    end
  end

  assign audio.valid     = v3;
  assign audio.sample    = sample3;
  assign audio.block_end = end3;

  // lookahead step tracks the current step plus slope
  a_ahead: assert property (@(posedge clk) disable iff (rst)
    ahead == ACC_W'(cs + sd))
    else $error("step lookahead out of step with current step and slope");

  // no slope outside a block
  a_idle_slope: assert property (@(posedge clk) disable iff (rst)
    (sl == '0) |-> (sd == '0 && gd == '0))
    else $error("nonzero slope with no block running");

  // divider result only expected while waiting for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

endmodule

### rtl/sine_oscillator_with_glide_top.sv
// Each accepted request yields one sample through the table and gain pipeline;
// a request that starts a block first waits for the serial slope divider.
// Throughput: one sample per cycle between block starts while the receiver is
// ready; each block start costs one divider run over the 48-bit step.
// Reset (rst, synchronous) clears phase, step, gain, slopes and the queue.
// ----------------------------------------------------------------------------
// sine_oscillator_with_glide_top
// Direct digital synthesis sine oscillator with step glide and gain ramp.
// ----------------------------------------------------------------------------
module sine_oscillator_with_glide_top #(
  parameter int SINE_TABLE_DEPTH = sinosc_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int MAX_BLOCK        = sinosc_pkg::MAX_BLOCK_DEF,
  parameter int PHASE_BITS       = sinosc_pkg::PHASE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  sinosc_in_if.sink    ctrl,
  sinosc_out_if.source audio
);
  import sinosc_pkg::*;

  cmd_t     front_cmd;
  logic     push;
  logic     room;
  logic     pop;
  logic     head_valid;
  cmd_t     head_cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // request intake
  sinosc_front #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .ctrl (ctrl),
    .cmd  (front_cmd),
    .push (push),
    .room (room)
  );

  // decoupling queue
  sinosc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_cmd     (front_cmd),
    .room       (room),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // slope divider
  sinosc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // oscillator core
  sinosc_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_BITS       (PHASE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .audio      (audio)
  );

endmodule

### verif/sine_oscillator_with_glide_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sine_oscillator_with_glide_top_test
// Drives control requests into the oscillator and checks every sample and
// block_end flag against a cycle-free predictor of the phase accumulator,
// step glide and gain ramp. A short directed table comes first, then random
// blocks (well formed, cut short, ticks outside a block) with random
// back-pressure, one long receiver hold-off and one full drain pause.
// ----------------------------------------------------------------------------
module sine_oscillator_with_glide_top_test;
  import sinosc_pkg::*;

  localparam int QUARTER   = SINE_TABLE_DEPTH_DEF / 4;
  localparam int MAX_LEN   = MAX_BLOCK_DEF;
  localparam int N_RANDOM  = 700;
  localparam int HOLD_AT   = 300;   // samples received before the long hold-off
  localparam int HOLD_LEN  = 400;   // cycles of the long hold-off
  localparam int PAUSE_AT  = 400;   // requests sent before the drain pause
  localparam int TAIL      = 100;   // cycles after the last sample

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
  } sample_word_t;

  typedef struct packed {
    logic                       start;
    logic [LEN_W-1:0]           len;
    logic [STEP_W-1:0]          step;
    logic [LEVEL_W-1:0]         level;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
  } tick_row_t;

  logic clk = 1'b0;
  logic rst;

  sinosc_in_if  ctrl_ch ();
  sinosc_out_if audio_ch ();

  sine_oscillator_with_glide_top u_dut (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl_ch),
    .audio (audio_ch)
  );

  always #5 clk = ~clk;

  // quarter-wave sine magnitudes and oscillator state of the predictor
  int unsigned        sine_quarter [0:QUARTER];
  logic [31:0]        osc_phase      = '0;
  logic [63:0]        osc_step       = '0;  // Q32.16 phase step
  longint             osc_step_slope = 0;
  logic [GAIN_W-1:0]  osc_gain       = '0;  // Q15.16 gain
  int                 osc_gain_slope = 0;
  int unsigned        osc_left       = 0;
  logic [STEP_W-1:0]  osc_end_step   = '0;
  logic [LEVEL_W-1:0] osc_end_level  = '0;

  sample_word_t pending_samples [$];
  sample_word_t head;
  int           mismatches    = 0;
  int           samples_seen  = 0;
  int           requests_sent = 0;

  // directed ticks; typed rows carry a hand-worked sample
  tick_row_t directed_ticks [0:20] = '{
    // block from zero gain: first sample silent, quarter-cycle step
    '{1'b1, 13'd1,    32'h4000_0000, 15'd32767, 1'b1, 16'sd0,      1'b1},
    '{1'b0, 13'd0,    32'h0000_0000, 15'd0,     1'b1, 16'sd32766,  1'b0},
    '{1'b0, 13'd0,    32'h0000_0000, 15'd0,     1'b1, 16'sd0,      1'b0},
    '{1'b0, 13'd0,    32'h0000_0000, 15'd0,     1'b1, -16'sd32766, 1'b0},
    // zero length with an unchanged step, phase back at zero
    '{1'b1, 13'd0,    32'h4000_0000, 15'd32767, 1'b1, 16'sd0,      1'b1},
    // length above the maximum, top step, level down to zero
    '{1'b1, 13'h1FFF, 32'hFFFF_FFFF, 15'd0,     1'b0, 16'sd0,      1'b0},
    '{1'b0, 13'h1FFF, 32'hFFFF_FFFF, 15'h7FFF,  1'b0, 16'sd0,      1'b0},
    '{1'b0, 13'h0AAA, 32'h5555_5555, 15'h2AAA,  1'b0, 16'sd0,      1'b0},
    // restart inside the running block
    '{1'b1, 13'd4097, 32'h0000_0000, 15'd32767, 1'b0, 16'sd0,      1'b0},
    '{1'b0, 13'h1555, 32'hAAAA_AAAA, 15'h5555,  1'b0, 16'sd0,      1'b0},
    '{1'b0, 13'd0,    32'h0000_0000, 15'd0,     1'b0, 16'sd0,      1'b0},
    '{1'b1, 13'd4096, 32'h1234_5678, 15'h5555,  1'b0, 16'sd0,      1'b0},
    '{1'b0, 13'd0,    32'h0000_0000, 15'd0,     1'b0, 16'sd0,      1'b0},
    '{1'b1, 13'd2,    32'h0ABC_DEF0, 15'h2AAA,  1'b0, 16'sd0,      1'b0},
    '{1'b0, 13'd0,    32'h0000_0000, 15'd0,     1'b0, 16'sd0,      1'b0},
    // tick outside a block
    '{1'b0, 13'd7,    32'hDEAD_BEEF, 15'd100,   1'b0, 16'sd0,      1'b0},
    '{1'b1, 13'd3,    32'hFFFF_FFFF, 15'd32767, 1'b0, 16'sd0,      1'b0},
    '{1'b0, 13'd0,    32'h0000_0000, 15'd0,     1'b0, 16'sd0,      1'b0},
    '{1'b0, 13'd0,    32'h0000_0000, 15'd0,     1'b0, 16'sd0,      1'b0},
    '{1'b1, 13'd1,    32'h0000_0000, 15'd0,     1'b0, 16'sd0,      1'b0},
    // gain now zero: silent outside the block
    '{1'b0, 13'd0,    32'h0000_0000, 15'd0,     1'b1, 16'sd0,      1'b0}
  };

  // one tick of the oscillator: latch, emit, ramp, advance, count down
  function automatic sample_word_t osc_advance(input logic start,
                                               input logic [LEN_W-1:0] len_in,
                                               input logic [STEP_W-1:0] step_in,
                                               input logic [LEVEL_W-1:0] level_in);
    int unsigned  len;
    longint       target;
    longint       gain_diff;
    logic [9:0]   idx;
    int unsigned  w;
    int unsigned  mag;
    int unsigned  g;
    sample_word_t word;
    if (start) begin
      len = len_in;
      if (len == 0) len = 1;
      if (len > MAX_LEN) len = MAX_LEN;
      osc_end_step  = step_in;
      osc_end_level = level_in;
      target = longint'({step_in, 16'h0000});
      if (target != longint'(osc_step))
        osc_step_slope = (target - longint'(osc_step)) / longint'(len);
      else
        osc_step_slope = 0;
      gain_diff      = longint'({level_in, 16'h0000}) - longint'(osc_gain);
      osc_gain_slope = int'(gain_diff / longint'(len));
      osc_left       = len;
    end
    // quarter-wave lookup, mirrored in odd quadrants, negated in the lower half
    idx = osc_phase[31:22];
    w   = idx[7:0];
    mag = idx[8] ? sine_quarter[QUARTER - w] : sine_quarter[w];
    g   = osc_gain >> 16;
    mag = (mag * g + 32'd16384) >> 15;
    word.sample    = idx[9] ? SAMPLE_W'(-int'(mag)) : SAMPLE_W'(mag);
    word.block_end = 1'b0;
    if (osc_left > 0) begin
      osc_step = osc_step + osc_step_slope;
      osc_gain = osc_gain + osc_gain_slope;
    end
    osc_phase = osc_phase + osc_step[47:16];
    // last sample of the block snaps to the targets
    if (osc_left > 0) begin
      osc_left--;
      if (osc_left == 0) begin
        word.block_end = 1'b1;
        osc_step       = {osc_end_step, 16'h0000};
        osc_gain       = {osc_end_level, 16'h0000};
        osc_step_slope = 0;
        osc_gain_slope = 0;
      end
    end
    return word;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return osc_step[47:16];  // equal target when no fraction is left
    if (roll < 22) return '0;
    if (roll < 30) return '1;
    if (roll < 50) return $urandom_range(0, 32'h0100_0000);
    return $urandom();
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return 15'h7FFF;
    return LEVEL_W'($urandom_range(0, 32767));
  endfunction

  // offer one request, predict it on acceptance, then maybe idle
  task automatic send_request(input logic start, input logic [LEN_W-1:0] len,
                              input logic [STEP_W-1:0] step,
                              input logic [LEVEL_W-1:0] level,
                              input logic typed, input sample_word_t typed_word);
    sample_word_t predicted;
    int           gap;
    ctrl_ch.valid        <= 1'b1;
    ctrl_ch.block_start  <= start;
    ctrl_ch.block_length <= len;
    ctrl_ch.target_step  <= step;
    ctrl_ch.target_level <= level;
    do @(posedge clk); while (!ctrl_ch.ready);
    predicted = osc_advance(start, len, step, level);
    pending_samples.push_back(typed ? typed_word : predicted);
    requests_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      ctrl_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sample checker
  always @(posedge clk) begin
    if (!rst && audio_ch.valid && audio_ch.ready) begin
      samples_seen++;
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sample %0d end %0b", audio_ch.sample, audio_ch.block_end);
      end else begin
        head = pending_samples.pop_front();
        if (audio_ch.sample !== head.sample || audio_ch.block_end !== head.block_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample mismatch: got %0d end %0b, expected %0d end %0b",
                     audio_ch.sample, audio_ch.block_end, head.sample, head.block_end);
        end
      end
    end
  end

  // receiver back-pressure, with one long hold-off while requests keep coming
  initial begin
    bit held;
    held = 1'b0;
    audio_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && samples_seen >= HOLD_AT) begin
        held = 1'b1;
        audio_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        audio_ch.ready <= 1'b1;
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(100, 300)) @(posedge clk);
        else
          repeat ($urandom_range(1, 40)) @(posedge clk);
        audio_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // stimulus
  initial begin
    longint unsigned tx, tx2, term, acc, rnd;
    int              i, k, j, roll, len, cut;
    bit              paused;
    paused = 1'b0;

    // quarter-wave table by Q30 series to the x^13 term
    for (i = 0; i <= QUARTER; i++) begin
      tx   = (longint'(i) * HALF_PI_Q30) / QUARTER;
      tx2  = (tx * tx) >> 30;
      term = tx;
      acc  = tx;
      for (k = 1; k <= 6; k++) begin
        term = ((term * tx2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) acc = acc - term;
        else            acc = acc + term;
      end
      rnd = (acc + 64'd16384) >> 15;
      if (rnd > SINE_MAX) rnd = SINE_MAX;
      sine_quarter[i] = int'(rnd);
    end

    rst                  = 1'b1;
    ctrl_ch.valid        = 1'b0;
    ctrl_ch.block_start  = 1'b0;
    ctrl_ch.block_length = '0;
    ctrl_ch.target_step  = '0;
    ctrl_ch.target_level = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (i = 0; i < $size(directed_ticks); i++)
      send_request(directed_ticks[i].start, directed_ticks[i].len,
                   directed_ticks[i].step, directed_ticks[i].level,
                   directed_ticks[i].typed,
                   '{directed_ticks[i].sample, directed_ticks[i].block_end});

    // drain before the random part
    ctrl_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);

    // random blocks
    while (requests_sent < N_RANDOM + $size(directed_ticks)) begin
      if (!paused && requests_sent >= PAUSE_AT) begin
        paused = 1'b1;
        ctrl_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_samples.size() != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        // well-formed block run to its end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        send_request(1'b1, LEN_W'(len), pick_step(), pick_level(), 1'b0, '0);
        for (j = 1; j < len; j++)
          send_request(1'b0, LEN_W'($urandom()), $urandom(), LEVEL_W'($urandom()),
                       1'b0, '0);
      end else if (roll < 80) begin
        // ticks outside a block
        cut = $urandom_range(1, 6);
        for (j = 0; j < cut; j++)
          send_request(1'b0, LEN_W'($urandom()), $urandom(), LEVEL_W'($urandom()),
                       1'b0, '0);
      end else begin
        // any length, usually cut short by the next block start
        len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 30);
        cut = $urandom_range(0, (len > 20) ? 20 : len);
        send_request(1'b1, LEN_W'(len), pick_step(), pick_level(), 1'b0, '0);
        for (j = 0; j < cut; j++)
          send_request(1'b0, LEN_W'($urandom()), $urandom(), LEVEL_W'($urandom()),
                       1'b0, '0);
      end
    end

    // wait out the last samples
    ctrl_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0 && pending_samples.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
